@@ hdl/sxu_pkg.sv @@
// ----------------------------------------------------------------------------
// sxu_pkg
// shared types and constants for the sysex seven-bit unpacker
// ----------------------------------------------------------------------------
package sxu_pkg;

    localparam int unsigned HDR_W = 40;
    localparam logic [HDR_W-1:0] HDR_RESET = 40'hF000026100;
    localparam logic [7:0] END_BYTE = 8'hF7;
    localparam logic [2:0] SLOT_HIGH = 3'd0;
    localparam logic [2:0] SLOT_LAST = 3'd7;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    // up to two decoded bytes from one input transfer
    typedef struct packed {
        logic [1:0] cnt;
        t_item      item0;
        t_item      item1;
    } t_push;

endpackage

@@ hdl/sxu_front.sv @@
// ----------------------------------------------------------------------------
// sxu_front
// header check, group tracking and seven-to-eight bit decode of each byte
// ----------------------------------------------------------------------------
module sxu_front import sxu_pkg::*; #(
    parameter int unsigned HEADER_LEN = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    input  logic [HDR_W-1:0] i_hdr_pattern,
    output t_push            o_push
);

    localparam int unsigned IDX_W = $clog2(HEADER_LEN + 1);

    logic [IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic             r_hdr_ok, n_hdr_ok;
    logic [2:0]       r_slot, n_slot;
    logic [6:0]       r_high, n_high;
    logic [7:0]       r_held, n_held;
    logic             r_held_v, n_held_v;
    logic [7:0]       w_hdr_byte;
    logic [2:0]       w_bit_sel;
    t_push            w_push;

    always_comb begin
        logic [63:0] shifted;
        w_hdr_byte = 8'd0;
        for (int i = 0; i < HEADER_LEN; i++) begin
            shifted = {{(64 - HDR_W){1'b0}}, i_hdr_pattern} >> (8 * (HEADER_LEN - 1 - i));
            if (r_hdr_idx == IDX_W'(i)) begin
                w_hdr_byte = shifted[7:0];
            end
        end
    end

    assign w_bit_sel = r_slot - 3'd1;

    always_comb begin
        logic [7:0] dec;
        logic       term;
        n_hdr_idx = r_hdr_idx;
        n_hdr_ok  = r_hdr_ok;
        n_slot    = r_slot;
        n_high    = r_high;
        n_held    = r_held;
        n_held_v  = r_held_v;
        w_push    = '0;
        dec       = {r_high[w_bit_sel], i_in_byte[6:0]};
        term      = i_in_last && (i_in_byte == END_BYTE);

        if (i_accept) begin
            if (r_hdr_idx < IDX_W'(HEADER_LEN)) begin
                if (i_in_byte != w_hdr_byte) begin
                    n_hdr_ok = 1'b0;
                end
                n_hdr_idx = r_hdr_idx + IDX_W'(1);
            end else if (r_hdr_ok) begin
                if (term) begin
                    n_slot = r_slot;
                end else if (r_slot == SLOT_HIGH) begin
                    n_high = i_in_byte[6:0];
                    n_slot = 3'd1;
                end else begin
                    if (r_held_v) begin
                        w_push.item0 = '{data: r_held, last: 1'b0};
                        w_push.cnt   = 2'd1;
                    end
                    n_held   = dec;
                    n_held_v = 1'b1;
                    n_slot   = (r_slot == SLOT_LAST) ? SLOT_HIGH : r_slot + 3'd1;
                end
                if (i_in_last && n_held_v) begin
                    if (w_push.cnt == 2'd0) begin
                        w_push.item0 = '{data: n_held, last: 1'b1};
                    end else begin
                        w_push.item1 = '{data: n_held, last: 1'b1};
                    end
                    w_push.cnt = w_push.cnt + 2'd1;
                end
            end

            if (i_in_last) begin
                n_hdr_idx = '0;
                n_hdr_ok  = 1'b1;
                n_slot    = SLOT_HIGH;
                n_high    = 7'd0;
                n_held_v  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= '0;
            r_hdr_ok  <= 1'b1;
            r_slot    <= SLOT_HIGH;
            r_high    <= 7'd0;
            r_held_v  <= 1'b0;
        end else begin
            r_hdr_idx <= n_hdr_idx;
            r_hdr_ok  <= n_hdr_ok;
            r_slot    <= n_slot;
            r_high    <= n_high;
            r_held_v  <= n_held_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    assign o_push = w_push;

endmodule

@@ hdl/sxu_queue.sv @@
// ----------------------------------------------------------------------------
// sxu_queue
// short result queue, two writes and one read per cycle
// ----------------------------------------------------------------------------
module sxu_queue import sxu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_push i_push,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_pop;

    assign w_pop    = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.cnt);
    assign n_rd_ptr = r_rd_ptr + QPTR_W'(w_pop);
    assign n_count  = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.item1;
        end
    end

    // room for two is kept so a single input transfer never overflows
    assign o_full  = r_count > QCNT_W'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

endmodule

@@ hdl/sysex_seven_bit_unpacker.sv @@
// output: a decoded byte is written into the result queue by the input transfer
//   that releases it (the held byte is released by the next data byte or the last byte)
// throughput: one input byte per cycle unless the four-entry result queue stalls
//   the input, which it does while fewer than two entries are free
// reset: synchronous, active low; clears message state and the queue and
//   loads the header register with F0 00 02 61 00
// ----------------------------------------------------------------------------
// sysex_seven_bit_unpacker
// top level: header register, decode front end and result queue
// ----------------------------------------------------------------------------
module sysex_seven_bit_unpacker import sxu_pkg::*; #(
    parameter int unsigned HEADER_LEN = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [HDR_W-1:0] i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    logic [HDR_W-1:0] r_hdr_pattern;
    logic             w_full;
    logic             w_accept;
    t_push            w_push;
    t_item            w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pattern <= HDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_hdr_pattern <= i_cfg_wr_data;
        end
    end

    assign w_accept = i_valid && !w_full;
    assign o_stall  = w_full;

    sxu_front #(
        .HEADER_LEN (HEADER_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .i_hdr_pattern (r_hdr_pattern),
        .o_push        (w_push)
    );

    sxu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (!i_stall),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_item  (w_item)
    );

    assign o_out_byte = w_item.data;
    assign o_out_last = w_item.last;

endmodule

@@ hdl/sxu_checker.sv @@
// ----------------------------------------------------------------------------
// sxu_checker
// port-level checks on the unpacker, attached by bind
// ----------------------------------------------------------------------------
module sxu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("stalled output transfer changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with nothing queued");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && !o_stall) |=> !o_valid)
        else $error("output appeared without an input transfer");

endmodule

bind sysex_seven_bit_unpacker sxu_checker u_sxu_checker (.*);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sysex seven-bit unpacker. A short table of
// hand-picked messages goes first. Some rows carry their decoded bytes typed
// in, and the rest are checked against an in-bench model of header match,
// group decode and held-back last byte. Four header settings follow, each
// with random messages: mostly well-formed, some with a broken header, some
// cut short and some plain noise. Both sides idle at random. Once, the
// receiver holds off long enough to fill the result queue.
// ----------------------------------------------------------------------------
module tb_top;
    import sxu_pkg::*;

    localparam int HDR_LEN    = 5;
    localparam int WDOG_LIMIT = 3000;
    localparam int SETTLE_CYC = 8;
    localparam int PHASE_LEN  = 320;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;
        int         n;
        t_item      e0;
        t_item      e1;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [HDR_W-1:0] i_cfg_wr_data;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_in_byte;
    logic             i_in_last;
    logic             o_valid;
    logic             i_stall;
    logic [7:0]       o_out_byte;
    logic             o_out_last;

    // model state
    logic [HDR_W-1:0] hdr_pat;
    int               hdr_idx;
    logic             hdr_ok;
    logic [2:0]       grp_slot;
    logic [6:0]       hi_bits;
    logic [7:0]       held;
    logic             held_v;

    t_item pending_bytes [$];
    int    mismatch_cnt = 0;
    int    sent_cnt = 0;
    int    rx_cnt = 0;
    int    idle_cyc = 0;

    t_row dir_tab [23];

    sysex_seven_bit_unpacker #(.HEADER_LEN(HDR_LEN)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] hdr_byte(input int i);
        return hdr_pat[8*(HDR_LEN-1-i) +: 8];
    endfunction

    function automatic void clear_msg();
        hdr_idx  = 0;
        hdr_ok   = 1'b1;
        grp_slot = SLOT_HIGH;
        hi_bits  = '0;
        held     = '0;
        held_v   = 1'b0;
    endfunction

    // decoded bytes released by one input byte, oldest in r0
    function automatic int unpack_step(input logic [7:0] b, input logic last,
                                       output t_item r0, output t_item r1);
        int n;
        logic [7:0] dec;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (hdr_idx < HDR_LEN) begin
            if (b != hdr_byte(hdr_idx))
                hdr_ok = 1'b0;
            hdr_idx++;
        end else if (hdr_ok) begin
            if (!(last && b == END_BYTE)) begin
                if (grp_slot == SLOT_HIGH) begin
                    hi_bits  = b[6:0];
                    grp_slot = 3'd1;
                end else begin
                    dec = {hi_bits[grp_slot - 3'd1], b[6:0]};
                    if (held_v) begin
                        r0 = '{data: held, last: 1'b0};
                        n  = 1;
                    end
                    held     = dec;
                    held_v   = 1'b1;
                    grp_slot = (grp_slot == SLOT_LAST) ? SLOT_HIGH : grp_slot + 3'd1;
                end
            end
            if (last && held_v) begin
                if (n == 0)
                    r0 = '{data: held, last: 1'b1};
                else
                    r1 = '{data: held, last: 1'b1};
                n++;
            end
        end
        if (last)
            clear_msg();
        return n;
    endfunction

    task automatic send_item(input t_row r);
        int gap;
        int roll;
        int n;
        t_item r0;
        t_item r1;
        gap = 0;
        if ((sent_cnt / 128) % 3 != 0) begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
                gap = $urandom_range(5, 30);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= r.b;
        i_in_last <= r.last;
        do @(posedge i_clk); while (o_stall);
        sent_cnt++;
        n = unpack_step(r.b, r.last, r0, r1);
        if (r.typed) begin
            n  = r.n;
            r0 = r.e0;
            r1 = r.e1;
        end
        if (n > 0)
            pending_bytes.push_back(r0);
        if (n > 1)
            pending_bytes.push_back(r1);
    endtask

    task automatic send_random_message();
        logic [7:0] msg [$];
        t_row r;
        int roll;
        int len;
        int bad;
        roll = $urandom_range(0, 99);
        for (int i = 0; i < HDR_LEN; i++)
            msg.push_back((roll >= 14 && roll < 18) ? 8'($urandom_range(0, 255)) : hdr_byte(i));
        if (roll < 8) begin
            bad = $urandom_range(0, HDR_LEN - 1);
            msg[bad] = msg[bad] ^ 8'($urandom_range(1, 255));
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
        for (int i = 0; i < len; i++)
            msg.push_back(($urandom_range(0, 15) == 0) ? END_BYTE : 8'($urandom_range(0, 255)));
        if (roll >= 8 && roll < 14)
            msg = msg[0:$urandom_range(0, HDR_LEN - 1)];
        else if (msg.size() == HDR_LEN || $urandom_range(0, 1) == 1)
            msg.push_back(END_BYTE);
        for (int i = 0; i < msg.size(); i++) begin
            r = '{msg[i], (i == msg.size() - 1), 1'b0, 0, '0, '0};
            send_item(r);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [HDR_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        hdr_pat = v;
    endtask

    // result side: random stall, one long hold-off
    initial begin
        int hold_left;
        int roll;
        int cyc;
        bit held_long;
        t_item want;
        hold_left = 0;
        cyc       = 0;
        held_long = 0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && o_valid && !i_stall) begin
                rx_cnt++;
                if (pending_bytes.size() == 0) begin
                    $error("unexpected transfer: out_byte %h out_last %b", o_out_byte, o_out_last);
                    mismatch_cnt++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, o_out_byte);
                        mismatch_cnt++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %b, got %b", want.last, o_out_last);
                        mismatch_cnt++;
                    end
                end
            end
            if (hold_left == 0) begin
                if (!held_long && rx_cnt >= 300) begin
                    hold_left = 400;
                    held_long = 1;
                end else if ((cyc / 256) % 3 != 0) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 25)
                        hold_left = $urandom_range(1, 3);
                    else if (roll < 28)
                        hold_left = $urandom_range(8, 40);
                end
            end
            i_stall <= (hold_left > 0);
            if (hold_left > 0)
                hold_left--;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en)
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [HDR_W-1:0] phase_hdr [4];
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_in_byte     = '0;
        i_in_last     = 1'b0;
        hdr_pat       = HDR_RESET;
        clear_msg();

        dir_tab = '{
            // final data byte, non-final terminator value, unused high bit
            '{8'hF0, 1'b0, 1'b1, 0, '0, '0},
            '{8'h00, 1'b0, 1'b1, 0, '0, '0},
            '{8'h02, 1'b0, 1'b1, 0, '0, '0},
            '{8'h61, 1'b0, 1'b1, 0, '0, '0},
            '{8'h00, 1'b0, 1'b1, 0, '0, '0},
            '{8'hFF, 1'b0, 1'b1, 0, '0, '0},
            '{8'hF7, 1'b0, 1'b0, 0, '0, '0},
            '{8'h00, 1'b1, 1'b1, 2, '{8'hF7, 1'b0}, '{8'h80, 1'b1}},
            // terminator releases the held byte
            '{8'hF0, 1'b0, 1'b0, 0, '0, '0},
            '{8'h00, 1'b0, 1'b0, 0, '0, '0},
            '{8'h02, 1'b0, 1'b0, 0, '0, '0},
            '{8'h61, 1'b0, 1'b0, 0, '0, '0},
            '{8'h00, 1'b0, 1'b0, 0, '0, '0},
            '{8'h00, 1'b0, 1'b0, 0, '0, '0},
            '{8'h7F, 1'b0, 1'b0, 0, '0, '0},
            '{8'hF7, 1'b1, 1'b1, 1, '{8'h7F, 1'b1}, '0},
            // short message
            '{8'hF0, 1'b1, 1'b1, 0, '0, '0},
            // header mismatch
            '{8'hF0, 1'b0, 1'b1, 0, '0, '0},
            '{8'hFF, 1'b0, 1'b1, 0, '0, '0},
            '{8'h02, 1'b0, 1'b1, 0, '0, '0},
            '{8'h61, 1'b0, 1'b1, 0, '0, '0},
            '{8'h00, 1'b0, 1'b1, 0, '0, '0},
            '{8'h12, 1'b1, 1'b1, 0, '0, '0}
        };

        phase_hdr[0] = '1;
        phase_hdr[1] = '0;
        phase_hdr[2] = HDR_W'({$urandom(), $urandom()});
        phase_hdr[3] = HDR_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_item(dir_tab[i]);

        for (int p = 0; p < 4; p++) begin
            settle();
            write_header(phase_hdr[p]);
            while (sent_cnt < $size(dir_tab) + (p + 1) * PHASE_LEN)
                send_random_message();
        end
        settle();

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sysex_seven_bit_unpacker.f @@
hdl/sxu_pkg.sv
hdl/sxu_front.sv
hdl/sxu_queue.sv
hdl/sysex_seven_bit_unpacker.sv
hdl/sxu_checker.sv
tb/sv/tb_top.sv
